// ===== src/gb3_pkg.sv =====
// Shared types and constants of the 3x3 Gaussian blur block.
`timescale 1ns / 1ps
`default_nettype none

package gb3_pkg;

   // Field widths of the ports and registers.
   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   // Register reset values.
   localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   // Item kinds on the request channel.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Result queue sizing.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Per-item control decided when the item is accepted.
   typedef struct packed {
      logic emit;    // the item produces a result
      logic border;  // the result pixel lies on the frame border
      logic last;    // the result pixel is the last of the frame
   } ctl_type;

   // One result item.
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } result_type;

endpackage

`default_nettype wire

// ===== src/gb3_stencil.sv =====
// 3x3 neighbor window and the 1-2-1 blur stencil with border pass-through.
`timescale 1ns / 1ps
`default_nettype none

module gb3_stencil (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift_valid,
   input  wire gb3_pkg::ctl_type           shift_ctl,
   input  wire logic [gb3_pkg::PIX_W-1:0]  col_upper,
   input  wire logic [gb3_pkg::PIX_W-1:0]  col_middle,
   input  wire logic [gb3_pkg::PIX_W-1:0]  col_lower,
   output logic                            res_valid,
   output gb3_pkg::result_type             res
);

   localparam int SUM_W = gb3_pkg::CHAN_W + 4;

   logic [gb3_pkg::PIX_W-1:0] win_ff [3][3];
   logic                      res_valid_ff;
   gb3_pkg::ctl_type          res_ctl_ff;
   logic [gb3_pkg::CHAN_W-1:0] blur_chan [3];
   logic [gb3_pkg::CHAN_W-1:0] mid_chan [3];

   // Shift a new column into the window; the window is cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
         res_valid_ff <= 1'b0;
         res_ctl_ff   <= '0;
      end else begin
         if (shift_valid) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= col_upper;
            win_ff[1][2] <= col_middle;
            win_ff[2][2] <= col_lower;
         end
         res_valid_ff <= shift_valid && shift_ctl.emit;
         res_ctl_ff   <= shift_ctl;
      end
   end

   // Weighted sum per channel: corners once, edges twice, center four times.
   always_comb begin
      logic [SUM_W-1:0] corners;
      logic [SUM_W-1:0] edges;
      logic [SUM_W-1:0] total;
      for (int ch = 0; ch < 3; ch++) begin
         corners = SUM_W'(win_ff[0][0][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W])
                 + SUM_W'(win_ff[0][2][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W])
                 + SUM_W'(win_ff[2][0][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W])
                 + SUM_W'(win_ff[2][2][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W]);
         edges   = SUM_W'(win_ff[0][1][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W])
                 + SUM_W'(win_ff[1][0][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W])
                 + SUM_W'(win_ff[1][2][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W])
                 + SUM_W'(win_ff[2][1][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W]);
         mid_chan[ch] = win_ff[1][1][ch*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W];
         total = corners + (edges << 1) + (SUM_W'(mid_chan[ch]) << 2);
         blur_chan[ch] = total[SUM_W-1:4];
      end
   end

   // Border pixels pass the window center through unchanged.
   always_comb begin
      if (res_ctl_ff.border) begin
         res.red   = mid_chan[2];
         res.green = mid_chan[1];
         res.blue  = mid_chan[0];
      end else begin
         res.red   = blur_chan[2];
         res.green = blur_chan[1];
         res.blue  = blur_chan[0];
      end
      res.last = res_ctl_ff.last;
   end

   assign res_valid = res_valid_ff;

endmodule

`default_nettype wire

// ===== src/gaussian_blur_3x3_rgb_top.sv =====
// Top level of the streaming 3x3 Gaussian blur over RGB pixels.
//
// Usage: set image_width (index 0) and image_height (index 1) through the
// csr_ write port while the block is idle. Feed one frame in raster order on
// the req_ channel (op = pixel), then image_width + 1 flush items (op = flush).
// Each item moves one column through the window; the result for a pixel is
// caused by the item that arrives image_width + 1 items after it. Results
// leave on the rsp_ channel with frame_last high on the frame's last pixel.
// A result passes the s1 stage, the stencil register and the result queue before
// rsp_valid. Throughput: one item per cycle while req_ready is high, set by
// the single line memory that is read at acceptance and written back in the
// next cycle; a back-to-back access to the same column is forwarded around the
// memory. A four-entry result queue decouples the receiver: when it stalls,
// req_ready drops as soon as queued plus in-flight results fill the queue.
// Reset clears the counters, the window and the queue, and loads the register
// defaults (640 x 480). The line memory is not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_3x3_rgb_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_op,
   input  wire logic [gb3_pkg::CHAN_W-1:0]       req_in_red,
   input  wire logic [gb3_pkg::CHAN_W-1:0]       req_in_green,
   input  wire logic [gb3_pkg::CHAN_W-1:0]       req_in_blue,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [gb3_pkg::CHAN_W-1:0]            rsp_out_red,
   output logic [gb3_pkg::CHAN_W-1:0]            rsp_out_green,
   output logic [gb3_pkg::CHAN_W-1:0]            rsp_out_blue,
   output logic                                  rsp_frame_last,
   input  wire logic                             csr_wr_en,
   input  wire logic [gb3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [gb3_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int CMP_W   = ((ADDR_W > gb3_pkg::WIDTH_W) ? ADDR_W : gb3_pkg::WIDTH_W) + 1;
   localparam int ROW_W   = gb3_pkg::HEIGHT_W + 1;
   localparam int PIX_W   = gb3_pkg::PIX_W;

   // Configuration registers.
   logic [gb3_pkg::WIDTH_W-1:0]  image_width_ff;
   logic [gb3_pkg::HEIGHT_W-1:0] image_height_ff;

   // Position counters.
   logic [ADDR_W-1:0]            in_col_ff, in_col_in;
   logic [ADDR_W-1:0]            out_col_ff, out_col_in;
   logic [gb3_pkg::HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [CMP_W-1:0]             items_ff, items_in;

   // Effective geometry and control of the current request.
   logic [CMP_W-1:0]             width_ext;
   logic [CMP_W-1:0]             eff_w;
   logic [ROW_W-1:0]             eff_h;
   logic [CMP_W-1:0]             in_col_plus;
   logic [CMP_W-1:0]             out_col_plus;
   logic [ROW_W-1:0]             out_row_plus;
   logic                         col_end;
   logic                         row_end;
   gb3_pkg::ctl_type             ctl_now;
   logic                         accept;
   logic [PIX_W-1:0]             px_now;

   // Line memory: upper line in the high half, lower line in the low half.
   logic [2*PIX_W-1:0]           line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0]           mem_rd_ff;

   // Stage after the memory read.
   logic                         s1_valid_ff;
   gb3_pkg::ctl_type             s1_ctl_ff;
   logic [ADDR_W-1:0]            s1_addr_ff;
   logic [PIX_W-1:0]             s1_px_ff;
   logic                         s1_fwd_ff;
   logic [PIX_W-1:0]             s1_fwd_up_ff;
   logic [PIX_W-1:0]             s1_fwd_lo_ff;
   logic [PIX_W-1:0]             s1_up;
   logic [PIX_W-1:0]             s1_lo;
   logic                         fwd_in;

   // Stencil output and result queue.
   logic                         res_valid;
   gb3_pkg::result_type          res;
   gb3_pkg::result_type          fifo_mem [gb3_pkg::FIFO_DEPTH];
   logic [gb3_pkg::FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [gb3_pkg::FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [gb3_pkg::FIFO_CNT_W-1:0] fifo_count_ff;
   logic [gb3_pkg::FIFO_CNT_W-1:0] pending;
   logic                         pop;
   gb3_pkg::result_type          head;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= gb3_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= gb3_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gb3_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_wr_data[gb3_pkg::WIDTH_W-1:0];
            end
            gb3_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wr_data[gb3_pkg::HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective width and height: zero acts as one, width is capped.
   always_comb begin
      width_ext = CMP_W'(image_width_ff);
      if (width_ext == '0) begin
         eff_w = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         eff_w = CMP_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ext;
      end
      eff_h = (image_height_ff == '0) ? ROW_W'(1) : ROW_W'(image_height_ff);
   end

   assign accept = req_valid && req_ready;
   assign px_now = (req_op == gb3_pkg::OP_PIXEL) ? {req_in_red, req_in_green, req_in_blue}
                                                  : '0;

   // Per-item control and counter updates, all decided at acceptance.
   always_comb begin
      in_col_plus  = CMP_W'(in_col_ff) + CMP_W'(1);
      out_col_plus = CMP_W'(out_col_ff) + CMP_W'(1);
      out_row_plus = ROW_W'(out_row_ff) + ROW_W'(1);
      col_end      = out_col_plus >= eff_w;
      row_end      = out_row_plus >= eff_h;

      ctl_now.emit   = items_ff >= eff_w + CMP_W'(1);
      ctl_now.border = (out_row_ff == '0) || row_end || (out_col_ff == '0) || col_end;
      ctl_now.last   = row_end && col_end;

      in_col_in  = in_col_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      items_in   = items_ff;

      if (accept) begin
         if (in_col_plus >= eff_w) begin
            in_col_in = '0;
         end else begin
            in_col_in = in_col_plus[ADDR_W-1:0];
         end
         if (!ctl_now.emit) begin
            items_in = items_ff + CMP_W'(1);
         end else if (ctl_now.last) begin
            in_col_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            items_in   = '0;
         end else if (col_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + gb3_pkg::HEIGHT_W'(1);
         end else begin
            out_col_in = out_col_plus[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         items_ff   <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         items_ff   <= items_in;
      end
   end

   // Forward the previous item's write when it targets the column read now.
   assign fwd_in = s1_valid_ff && (s1_addr_ff == in_col_ff);
   assign s1_up  = s1_fwd_ff ? s1_fwd_up_ff : mem_rd_ff[2*PIX_W-1:PIX_W];
   assign s1_lo  = s1_fwd_ff ? s1_fwd_lo_ff : mem_rd_ff[PIX_W-1:0];

   // Line memory: read at acceptance, write back the shifted column next cycle.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= {s1_lo, s1_px_ff};
      end
      if (accept) begin
         mem_rd_ff <= line_mem[in_col_ff];
      end
   end

   // Stage registers behind the memory read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_ctl_ff   <= '0;
         s1_fwd_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_ctl_ff   <= accept ? ctl_now : '0;
         s1_fwd_ff   <= accept && fwd_in;
      end
      s1_addr_ff   <= in_col_ff;
      s1_px_ff     <= px_now;
      s1_fwd_up_ff <= s1_lo;
      s1_fwd_lo_ff <= s1_px_ff;
   end

   gb3_stencil u_stencil (
      .clock       (clock),
      .reset       (reset),
      .shift_valid (s1_valid_ff),
      .shift_ctl   (s1_ctl_ff),
      .col_upper   (s1_up),
      .col_middle  (s1_lo),
      .col_lower   (s1_px_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   // Admit an item only while every result in flight has a queue slot.
   assign pending = fifo_count_ff
                  + gb3_pkg::FIFO_CNT_W'(s1_valid_ff && s1_ctl_ff.emit)
                  + gb3_pkg::FIFO_CNT_W'(res_valid);
   assign req_ready = pending < gb3_pkg::FIFO_CNT_W'(gb3_pkg::FIFO_DEPTH);

   // Result queue.
   assign pop  = rsp_valid && rsp_ready;
   assign head = fifo_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (res_valid) begin
         fifo_mem[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (res_valid) begin
            wr_ptr_ff <= wr_ptr_ff + gb3_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + gb3_pkg::FIFO_PTR_W'(1);
         end
         fifo_count_ff <= fifo_count_ff + gb3_pkg::FIFO_CNT_W'(res_valid)
                        - gb3_pkg::FIFO_CNT_W'(pop);
      end
   end

   assign rsp_valid      = fifo_count_ff != '0;
   assign rsp_out_red    = head.red;
   assign rsp_out_green  = head.green;
   assign rsp_out_blue   = head.blue;
   assign rsp_frame_last = head.last;

`ifndef SYNTH
   // Results in flight never exceed the queue depth.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pending <= gb3_pkg::FIFO_CNT_W'(gb3_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // An item that produces a result reaches the queue after the s1 stage and the stencil register.
   a_result_timing: assert property (@(posedge clock) disable iff (reset)
      (accept && ctl_now.emit) |-> ##2 res_valid)
      else $error("result lost in pipeline");

   // The last pixel of a frame rewinds every position counter.
   a_frame_rewind: assert property (@(posedge clock) disable iff (reset)
      (accept && ctl_now.emit && ctl_now.last) |=>
         (items_ff == '0 && in_col_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("counters not rewound at frame end");

   // Forwarding is only selected when the previous item has written back.
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> (s1_valid_ff && $past(s1_valid_ff)))
      else $error("forwarding without a write-back source");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming 3x3 Gaussian blur over RGB pixels.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_W = 1024;

   // Block inputs, all at known values from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = gb3_pkg::OP_PIXEL;
   logic [gb3_pkg::CHAN_W-1:0] req_in_red = '0;
   logic [gb3_pkg::CHAN_W-1:0] req_in_green = '0;
   logic [gb3_pkg::CHAN_W-1:0] req_in_blue = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [gb3_pkg::CHAN_W-1:0] rsp_out_red;
   logic [gb3_pkg::CHAN_W-1:0] rsp_out_green;
   logic [gb3_pkg::CHAN_W-1:0] rsp_out_blue;
   logic rsp_frame_last;
   logic csr_wr_en = 1'b0;
   logic [gb3_pkg::CSR_INDEX_W-1:0] csr_index = gb3_pkg::REG_IMAGE_WIDTH;
   logic [gb3_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   // Own copy of the block state, kept in step with accepted items.
   logic [gb3_pkg::WIDTH_W-1:0] cfg_width = gb3_pkg::IMAGE_WIDTH_RESET;
   logic [gb3_pkg::HEIGHT_W-1:0] cfg_height = gb3_pkg::IMAGE_HEIGHT_RESET;
   logic [gb3_pkg::PIX_W-1:0] upper_line [MAX_W];
   logic [gb3_pkg::PIX_W-1:0] lower_line [MAX_W];
   logic [gb3_pkg::PIX_W-1:0] win [3][3];
   int unsigned in_col = 0;
   int unsigned in_row = 0;
   int unsigned out_col = 0;
   int unsigned out_row = 0;
   int unsigned fill_cnt = 0;

   // Blurred pixels still owed by the block, oldest first.
   gb3_pkg::result_type blurred_pixels_q[$];

   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;
   int unsigned settings_used = 0;
   bit no_idle = 1'b0;

   gaussian_blur_3x3_rgb_top #(.MAX_WIDTH(MAX_W)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_in_red(req_in_red),
      .req_in_green(req_in_green),
      .req_in_blue(req_in_blue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .rsp_frame_last(rsp_frame_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Register values outside the legal range fall back to the nearest size.
   function automatic int unsigned eff_width(input int unsigned raw);
      if (raw == 0) return 1;
      if (raw > MAX_W) return MAX_W;
      return raw;
   endfunction

   function automatic int unsigned eff_height(input int unsigned raw);
      return (raw == 0) ? 1 : raw;
   endfunction

   function automatic int unsigned chan_of(input logic [gb3_pkg::PIX_W-1:0] px,
                                           input int sh);
      return (px >> sh) & 8'hFF;
   endfunction

   // Weighted 1-2-1 / 2-4-2 / 1-2-1 sum of one channel, divided by 16.
   function automatic logic [gb3_pkg::CHAN_W-1:0] blur_chan(input int sh);
      int unsigned s;
      s = chan_of(win[0][0], sh) + chan_of(win[0][2], sh)
        + chan_of(win[2][0], sh) + chan_of(win[2][2], sh)
        + 2 * (chan_of(win[0][1], sh) + chan_of(win[1][0], sh)
             + chan_of(win[1][2], sh) + chan_of(win[2][1], sh))
        + 4 * chan_of(win[1][1], sh);
      return gb3_pkg::CHAN_W'(s >> 4);
   endfunction

   // Shift one item through the window and queue the pixel it releases, if any.
   function automatic void predict_blur(input logic op,
                                        input logic [gb3_pkg::CHAN_W-1:0] r,
                                        input logic [gb3_pkg::CHAN_W-1:0] g,
                                        input logic [gb3_pkg::CHAN_W-1:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      logic [gb3_pkg::PIX_W-1:0] px;
      logic [gb3_pkg::PIX_W-1:0] up;
      logic [gb3_pkg::PIX_W-1:0] lo;
      logic border;
      logic last;
      gb3_pkg::result_type res;
      w = eff_width(cfg_width);
      h = eff_height(cfg_height);
      px = (op == gb3_pkg::OP_PIXEL) ? {r, g, b} : '0;
      col = (in_col < MAX_W) ? in_col : MAX_W - 1;
      up = upper_line[col];
      lo = lower_line[col];
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = px;
      upper_line[col] = lo;
      lower_line[col] = px;

      if (in_col + 1 >= w) begin
         in_col = 0;
         in_row = (in_row + 1) & 16'hFFFF;
      end else begin
         in_col++;
      end

      // The window is not yet full enough to release a pixel.
      if (fill_cnt < w + 1) begin
         fill_cnt++;
         return;
      end

      border = (out_row == 0) || (out_row + 1 >= h)
            || (out_col == 0) || (out_col + 1 >= w);
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      if (border) begin
         res.red = win[1][1][23:16];
         res.green = win[1][1][15:8];
         res.blue = win[1][1][7:0];
      end else begin
         res.red = blur_chan(16);
         res.green = blur_chan(8);
         res.blue = blur_chan(0);
      end
      res.last = last;
      blurred_pixels_q.push_back(res);

      if (last) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         fill_cnt = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row = (out_row + 1) & 16'hFFFF;
      end else begin
         out_col++;
      end
   endfunction

   function automatic bit frame_open();
      return (in_col != 0) || (in_row != 0) || (out_col != 0) || (out_row != 0)
          || (fill_cnt != 0);
   endfunction

   // Channel values lean toward the extremes now and then.
   function automatic logic [gb3_pkg::CHAN_W-1:0] rand_chan();
      int unsigned k;
      k = $urandom_range(7);
      if (k == 0) return '0;
      if (k == 1) return '1;
      return gb3_pkg::CHAN_W'($urandom_range(255));
   endfunction

   // Send one item: optional idle cycles, then hold valid until accepted.
   task automatic send_item(input logic op, input logic [gb3_pkg::CHAN_W-1:0] r,
                            input logic [gb3_pkg::CHAN_W-1:0] g,
                            input logic [gb3_pkg::CHAN_W-1:0] b);
      while (!no_idle && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_in_red <= r;
      req_in_green <= g;
      req_in_blue <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      predict_blur(op, r, g, b);
   endtask

   // Let the block drain completely before touching its registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (blurred_pixels_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Both registers are written in turn, width first, without dropping csr_wr_en.
   task automatic set_frame_size(input int unsigned w, input int unsigned h);
      csr_wr_en <= 1'b1;
      csr_index <= gb3_pkg::REG_IMAGE_WIDTH;
      csr_wr_data <= gb3_pkg::CSR_DATA_W'(w[gb3_pkg::WIDTH_W-1:0]);
      @(posedge clock);
      cfg_width = w[gb3_pkg::WIDTH_W-1:0];
      csr_index <= gb3_pkg::REG_IMAGE_HEIGHT;
      csr_wr_data <= h[gb3_pkg::HEIGHT_W-1:0];
      @(posedge clock);
      cfg_height = h[gb3_pkg::HEIGHT_W-1:0];
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Flush items until the block has released the last pixel of the frame.
   task automatic finish_frame();
      while (frame_open())
         send_item(gb3_pkg::OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
   endtask

   // One whole frame: pixels, some of them black flushes, then the drain items.
   task automatic run_frame(input int unsigned w, input int unsigned h,
                            input int unsigned flush_pct, input int unsigned stray_pct);
      int unsigned we;
      int unsigned he;
      wait_idle();
      set_frame_size(w, h);
      we = eff_width(w);
      he = eff_height(h);
      repeat (we * he)
         send_item(($urandom_range(99) < flush_pct) ? gb3_pkg::OP_FLUSH : gb3_pkg::OP_PIXEL,
                   rand_chan(), rand_chan(), rand_chan());
      repeat (we + 1)
         send_item(($urandom_range(99) < stray_pct) ? gb3_pkg::OP_PIXEL : gb3_pkg::OP_FLUSH,
                   rand_chan(), rand_chan(), rand_chan());
      finish_frame();
   endtask

   // Smallest frame with one interior pixel, every channel at full scale.
   task automatic test_saturated_frame();
      wait_idle();
      set_frame_size(3, 3);
      repeat (9) send_item(gb3_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      repeat (4) send_item(gb3_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);
   endtask

   // Toggling bit patterns, a flush inside the frame and a pixel in the drain.
   task automatic test_bit_patterns();
      wait_idle();
      set_frame_size(3, 3);
      for (int i = 0; i < 9; i++) begin
         if (i == 3) send_item(gb3_pkg::OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
         else if (i % 2 == 0) send_item(gb3_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h5A);
         else send_item(gb3_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'hA5);
      end
      send_item(gb3_pkg::OP_PIXEL, 8'hC3, 8'h3C, 8'h81);
      repeat (3) send_item(gb3_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);
   endtask

   // Zero sizes act as one; frames too thin to have an interior.
   task automatic test_degenerate_sizes();
      run_frame(0, 0, 0, 0);
      run_frame(1, 3, 0, 0);
      run_frame(2, 2, 0, 50);
      run_frame(4, 1, 0, 0);
   endtask

   // Height shrunk below the rows already produced ends the frame early.
   task automatic test_shrunk_height();
      wait_idle();
      set_frame_size(5, 6);
      repeat (20) send_item(gb3_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      wait_idle();
      set_frame_size(5, 1);
      finish_frame();
   endtask

   // Long rows with an interior line.
   task automatic test_long_rows();
      run_frame(64, 3, 5, 10);
   endtask

   // Tall frame, one column wide.
   task automatic test_tall_frame();
      run_frame(1, 100, 2, 10);
   endtask

   // Random frames, mostly small, with some cut short or overrun.
   task automatic test_random_frames();
      int unsigned first;
      int unsigned w;
      int unsigned h;
      int unsigned pick;
      int unsigned cut;
      first = items_sent;
      while (items_sent - first < 400) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            w = $urandom_range(12);
            h = $urandom_range(8);
         end else if (pick < 95) begin
            w = $urandom_range(13, 64);
            h = $urandom_range(1, 4);
         end else begin
            w = $urandom_range(65, 128);
            h = $urandom_range(1, 2);
         end
         // A long stretch with no idling on either side.
         no_idle = (items_sent - first >= 100) && (items_sent - first < 250);
         pick = $urandom_range(99);
         if (pick < 12) begin
            wait_idle();
            set_frame_size(w, h);
            cut = $urandom_range(1, eff_width(w) * eff_height(h) + eff_width(w));
            repeat (cut)
               send_item(($urandom_range(99) < 30) ? gb3_pkg::OP_FLUSH : gb3_pkg::OP_PIXEL,
                         rand_chan(), rand_chan(), rand_chan());
            finish_frame();
         end else begin
            run_frame(w, h, (pick < 30) ? 10 : 0, (pick < 50) ? 25 : 0);
         end
         // Now and then a few pixels run past the frame into the next one.
         if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 4))
               send_item(gb3_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
            finish_frame();
         end
      end
      no_idle = 1'b0;
   endtask

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      gb3_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (blurred_pixels_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: rgb %02h %02h %02h last %0b",
                        rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_last);
         end else begin
            want = blurred_pixels_q.pop_front();
            if (rsp_out_red !== want.red || rsp_out_green !== want.green
                || rsp_out_blue !== want.blue || rsp_frame_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch %0d: want %02h %02h %02h/%0b got %02h %02h %02h/%0b",
                           results_seen, want.red, want.green, want.blue, want.last,
                           rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_last);
            end
         end
      end
      rsp_ready <= no_idle || ($urandom_range(99) >= 17);
   end

   // Main sequence.
   initial begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = '0;
      for (int i = 0; i < MAX_W; i++) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_saturated_frame();
      test_bit_patterns();
      test_degenerate_sizes();
      test_shrunk_height();
      test_long_rows();
      test_tall_frame();
      test_random_frames();
      wait_idle();
      $display("Sent %0d items and checked %0d pixels over %0d frame sizes, %0d mismatches.",
               items_sent, results_seen, settings_used, mismatches);
      $display("Frames ran from 1x1 up to 128 columns or 100 rows, with flushes and stalls.");
      if (mismatches == 0 && blurred_pixels_q.size() == 0) begin
         $display("[gaussian_blur_3x3_rgb_top] OK");
      end else begin
         $display("[gaussian_blur_3x3_rgb_top] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2ms;
      $display("[gaussian_blur_3x3_rgb_top] ERROR");
      $finish;
   end

endmodule
